### sv/run_length_tile_decoder_defines.svh
// assertion macros for the run-length tile decoder
// no dependencies; the checks are left out when SYNTHESIS is defined
`ifndef RUN_LENGTH_TILE_DECODER_DEFINES_SVH
`define RUN_LENGTH_TILE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define RLTD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rltd: assertion failed");
`define RLTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rltd: assertion failed");
`else
`define RLTD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RLTD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### sv/rltd_pkg.sv
// shared types and constants of the run-length tile decoder
// no dependencies
package rltd_pkg;

   localparam int ADDR_W      = 14;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 7;
   localparam int REP_W       = 3;
   localparam int ROWS_W      = 6;
   localparam int EFF_ROWS_W  = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 14;
   localparam int SEG_MAX     = 4;
   localparam int SEG_LIMIT   = 36;
   localparam int SEG_CNT_W   = 6;
   localparam int RUN_FLAG_BIT = 7;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT    = 1'b1;

   localparam logic [ADDR_W-1:0] BASE_RESET = 14'd8192;
   localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd30;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic has_data;
      logic slot_free;
      logic seg_done;
   } status_type;

endpackage

### sv/rltd_controller.sv
// controller of the run-length tile decoder: accept and emit sequencing
// depends on rltd_pkg
module rltd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rltd_pkg::status_type status,
   output rltd_pkg::cmd_type    cmd
);

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.step  = (state_ff == ST_EMIT) && status.slot_free;
      req_ready = (state_ff == ST_IDLE);
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            // a data byte starts a segment sequence, a control byte does not
            if (req_valid && status.has_data) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cmd.step && status.seg_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/rltd_datapath.sv
// datapath of the run-length tile decoder: counters, position, segment split, result register
// depends on rltd_pkg and run_length_tile_decoder_defines.svh
`include "run_length_tile_decoder_defines.svh"

module rltd_datapath #(
   parameter int ROW_WIDTH = 32,
   parameter int MAX_ROWS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rltd_pkg::cmd_type                   cmd,
   output rltd_pkg::status_type                status,
   input  logic [rltd_pkg::BYTE_W-1:0]         req_coded_byte,
   input  logic                                csr_write_enable,
   input  logic [rltd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rltd_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rltd_pkg::ADDR_W-1:0]         rsp_out_address,
   output logic [rltd_pkg::BYTE_W-1:0]         rsp_out_value,
   output logic [rltd_pkg::REP_W-1:0]          rsp_repeat_count,
   output logic                                rsp_last_of_input,
   output logic                                rsp_picture_end
);

   localparam int CW = $clog2(ROW_WIDTH);
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [rltd_pkg::ADDR_W-1:0]    base_ff, base_in;
   logic [rltd_pkg::ROWS_W-1:0]    rows_ff, rows_in;
   logic [rltd_pkg::COUNT_W-1:0]   run_ff, run_in;
   logic [rltd_pkg::COUNT_W-1:0]   lit_ff, lit_in;
   logic [rltd_pkg::COUNT_W-1:0]   len_ff, len_in;
   logic [rltd_pkg::BYTE_W-1:0]    val_ff, val_in;
   logic [RW-1:0]                  row_ff, row_in;
   logic [CW-1:0]                  col_ff, col_in;
   logic [rltd_pkg::SEG_CNT_W-1:0] seg_cnt_ff, seg_cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [rltd_pkg::ADDR_W-1:0]    rsp_addr_ff;
   logic [rltd_pkg::BYTE_W-1:0]    rsp_value_ff;
   logic [rltd_pkg::REP_W-1:0]     rsp_rep_ff;
   logic                           rsp_last_ff;
   logic                           rsp_pe_ff;

   logic [CW:0]                        room_c;
   logic [rltd_pkg::REP_W-1:0]         seg_c;
   logic [CW:0]                        col_sum_c;
   logic                               row_end_c;
   logic [RW:0]                        row_nx_c;
   logic [rltd_pkg::EFF_ROWS_W-1:0]    eff_rows_c;
   logic                               pic_end_c;
   logic [rltd_pkg::COUNT_W-1:0]       len_rem_c;
   logic                               done_c;
   logic                               emit_ok_c;
   logic                               last_c;
   logic [rltd_pkg::ADDR_W-1:0]        addr_c;

   // segment split: at most four bytes, never past the row end
   always_comb begin
      room_c = (CW+1)'(ROW_WIDTH) - {1'b0, col_ff};
      if (len_ff < rltd_pkg::COUNT_W'(rltd_pkg::SEG_MAX)) seg_c = len_ff[rltd_pkg::REP_W-1:0];
      else                                              seg_c = rltd_pkg::REP_W'(rltd_pkg::SEG_MAX);
      if ((CW+1)'(seg_c) > room_c) seg_c = room_c[rltd_pkg::REP_W-1:0];
      col_sum_c = {1'b0, col_ff} + (CW+1)'(seg_c);
      row_end_c = col_sum_c >= (CW+1)'(ROW_WIDTH);
      row_nx_c  = {1'b0, row_ff} + (RW+1)'(1);
      if (rows_ff == '0)
         eff_rows_c = rltd_pkg::EFF_ROWS_W'(1);
      else if (rltd_pkg::EFF_ROWS_W'(rows_ff) > rltd_pkg::EFF_ROWS_W'(MAX_ROWS))
         eff_rows_c = rltd_pkg::EFF_ROWS_W'(MAX_ROWS);
      else
         eff_rows_c = rltd_pkg::EFF_ROWS_W'(rows_ff);
      pic_end_c = row_end_c && (rltd_pkg::EFF_ROWS_W'(row_nx_c) >= eff_rows_c);
      len_rem_c = len_ff - rltd_pkg::COUNT_W'(seg_c);
      done_c    = (len_rem_c == '0) || pic_end_c;
      emit_ok_c = seg_cnt_ff < rltd_pkg::SEG_CNT_W'(rltd_pkg::SEG_LIMIT);
      // the last segment that still fits the result limit closes the beat sequence
      last_c    = done_c || (seg_cnt_ff == rltd_pkg::SEG_CNT_W'(rltd_pkg::SEG_LIMIT - 1));
      addr_c    = base_ff + rltd_pkg::ADDR_W'(row_ff) * rltd_pkg::ADDR_W'(ROW_WIDTH)
                  + rltd_pkg::ADDR_W'(col_ff);
   end

   always_comb begin
      base_in      = base_ff;
      rows_in      = rows_ff;
      run_in       = run_ff;
      lit_in       = lit_ff;
      len_in       = len_ff;
      val_in       = val_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      seg_cnt_in   = seg_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_write_enable) begin
         case (csr_index)
            rltd_pkg::REG_BASE_ADDRESS: base_in = csr_write_data[rltd_pkg::ADDR_W-1:0];
            rltd_pkg::REG_ROW_COUNT:    rows_in = csr_write_data[rltd_pkg::ROWS_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         if (run_ff != '0) begin
            // byte is the run value
            len_in     = run_ff;
            run_in     = '0;
            val_in     = req_coded_byte;
            seg_cnt_in = '0;
         end else if (lit_ff != '0) begin
            lit_in     = lit_ff - rltd_pkg::COUNT_W'(1);
            len_in     = rltd_pkg::COUNT_W'(1);
            val_in     = req_coded_byte;
            seg_cnt_in = '0;
         end else if (req_coded_byte[rltd_pkg::RUN_FLAG_BIT]) begin
            run_in = req_coded_byte[rltd_pkg::COUNT_W-1:0];
         end else begin
            lit_in = req_coded_byte[rltd_pkg::COUNT_W-1:0];
         end
      end

      if (cmd.step) begin
         col_in = row_end_c ? '0 : col_sum_c[CW-1:0];
         len_in = pic_end_c ? '0 : len_rem_c;
         if (row_end_c) row_in = pic_end_c ? '0 : row_nx_c[RW-1:0];
         if (pic_end_c) begin
            run_in = '0;
            lit_in = '0;
         end
         if (emit_ok_c) begin
            seg_cnt_in   = seg_cnt_ff + rltd_pkg::SEG_CNT_W'(1);
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= rltd_pkg::BASE_RESET;
         rows_ff      <= rltd_pkg::ROWS_RESET;
         run_ff       <= '0;
         lit_ff       <= '0;
         len_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         seg_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         rows_ff      <= rows_in;
         run_ff       <= run_in;
         lit_ff       <= lit_in;
         len_ff       <= len_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         seg_cnt_ff   <= seg_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (cmd.step && emit_ok_c) begin
         rsp_addr_ff  <= addr_c;
         rsp_value_ff <= val_ff;
         rsp_rep_ff   <= seg_c;
         rsp_last_ff  <= last_c;
         rsp_pe_ff    <= pic_end_c;
      end
   end

   assign status.has_data  = (run_ff != '0) || (lit_ff != '0);
   assign status.slot_free = !rsp_valid_ff || rsp_ready;
   assign status.seg_done  = done_c;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_address   = rsp_addr_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_repeat_count  = rsp_rep_ff;
   assign rsp_last_of_input = rsp_last_ff;
   assign rsp_picture_end   = rsp_pe_ff;

   `RLTD_ASSERT_IMPLY(a_col_range, clock, reset, 1'b1, (CW+1)'(col_ff) < (CW+1)'(ROW_WIDTH))
   `RLTD_ASSERT_IMPLY(a_step_has_len, clock, reset, cmd.step, len_ff != '0)
   `RLTD_ASSERT_IMPLY(a_pe_is_last, clock, reset, rsp_valid_ff && rsp_pe_ff, rsp_last_ff)
   `RLTD_ASSERT_NEXT(a_wrap_home, clock, reset, cmd.step && pic_end_c, (row_ff == '0) && (col_ff == '0))

endmodule

### sv/run_length_tile_decoder.sv
// run-length tile decoder: control bytes give no beat; a data byte is accepted while idle,
// then each emit step, taken while the result slot is free, gives one segment beat up to
// the result limit; no new byte is accepted until the segments are done; a literal is one
// segment, a run is split at four bytes and at row ends; beats come from the result register
// reset is synchronous: base_address 8192, row_count 30, counters and position cleared
// depends on rltd_pkg, rltd_controller and rltd_datapath
module run_length_tile_decoder #(
   parameter int ROW_WIDTH = 32,
   parameter int MAX_ROWS  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rltd_pkg::BYTE_W-1:0]     req_coded_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rltd_pkg::ADDR_W-1:0]     rsp_out_address,
   output logic [rltd_pkg::BYTE_W-1:0]     rsp_out_value,
   output logic [rltd_pkg::REP_W-1:0]      rsp_repeat_count,
   output logic                            rsp_last_of_input,
   output logic                            rsp_picture_end,
   input  logic                            csr_write_enable,
   input  logic [rltd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rltd_pkg::CSR_DATA_W-1:0] csr_write_data
);

   rltd_pkg::cmd_type    cmd;
   rltd_pkg::status_type status;

   rltd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rltd_datapath #(
      .ROW_WIDTH (ROW_WIDTH),
      .MAX_ROWS  (MAX_ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_coded_byte    (req_coded_byte),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_address   (rsp_out_address),
      .rsp_out_value     (rsp_out_value),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_last_of_input (rsp_last_of_input),
      .rsp_picture_end   (rsp_picture_end)
   );

endmodule
